>>> sv/bmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_pkg: shared types and constants for the box min/max distance unit
// Coordinate width, derived datapath widths, request/response structs and
// the magnitude helper used by the axis lanes.
// ----------------------------------------------------------------------------
package bmm_pkg;

   localparam int COORD_BITS = 24;
   localparam int AXES       = 3;
   localparam int DIF_W      = COORD_BITS + 1;
   localparam int MAG_W      = COORD_BITS + 1;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = 2 * COORD_BITS + 2;
   localparam int ROOT_W     = COORD_BITS + 1;
   localparam int TEST_W     = SUM_W + 1;
   localparam int OUT_W      = 25;
   localparam int FRONT_ST   = 3;
   localparam int NUM_ST     = FRONT_ST + ROOT_W;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type a_low_x;
      coord_type a_low_y;
      coord_type a_low_z;
      coord_type a_high_x;
      coord_type a_high_y;
      coord_type a_high_z;
      coord_type b_low_x;
      coord_type b_low_y;
      coord_type b_low_z;
      coord_type b_high_x;
      coord_type b_high_y;
      coord_type b_high_z;
   } bmm_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] min_distance;
      logic [OUT_W-1:0] max_distance;
   } bmm_rsp_type;

   function automatic logic [MAG_W-1:0] abs_mag(input logic signed [DIF_W-1:0] d);
      logic signed [DIF_W-1:0] n;
      n = -d;
      return d[DIF_W-1] ? MAG_W'(n) : MAG_W'(d);
   endfunction

endpackage

>>> sv/bmm_axis_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_axis_lane: one axis of the interval comparison
// Stage one classifies the two intervals and picks gap and span magnitudes;
// stage two squares both.
// ----------------------------------------------------------------------------
module bmm_axis_lane (
   input  logic                         clock,
   input  logic                         en_mag,
   input  logic                         en_sq,
   input  bmm_pkg::coord_type           a_low,
   input  bmm_pkg::coord_type           a_high,
   input  bmm_pkg::coord_type           b_low,
   input  bmm_pkg::coord_type           b_high,
   output logic [bmm_pkg::SQ_W-1:0]     sq_min,
   output logic [bmm_pkg::SQ_W-1:0]     sq_max
);

   localparam int DW = bmm_pkg::DIF_W;
   localparam int MW = bmm_pkg::MAG_W;
   localparam int SW = bmm_pkg::SQ_W;

   logic signed [DW-1:0] al, ah, bl, bh;
   logic signed [DW-1:0] lo, hi;
   logic                 a_below, b_below;
   logic [MW-1:0]        min_mag_in, max_mag_in;
   logic [MW-1:0]        min_mag_ff, max_mag_ff;
   logic [SW-1:0]        sq_min_in, sq_max_in;
   logic [SW-1:0]        sq_min_ff, sq_max_ff;

   always_comb begin
      al      = DW'(a_low);
      ah      = DW'(a_high);
      bl      = DW'(b_low);
      bh      = DW'(b_high);
      a_below = ah < bl;
      b_below = bh < al;
      lo      = (al < bl) ? al : bl;
      hi      = (ah > bh) ? ah : bh;
      if (a_below) begin
         min_mag_in = bmm_pkg::abs_mag(bl - ah);
         max_mag_in = bmm_pkg::abs_mag(bh - al);
      end else if (b_below) begin
         min_mag_in = bmm_pkg::abs_mag(al - bh);
         max_mag_in = bmm_pkg::abs_mag(ah - bl);
      end else begin
         min_mag_in = '0;
         max_mag_in = bmm_pkg::abs_mag(hi - lo);
      end
      sq_min_in = SW'(min_mag_ff) * SW'(min_mag_ff);
      sq_max_in = SW'(max_mag_ff) * SW'(max_mag_ff);
   end

   always_ff @(posedge clock) begin
      if (en_mag) begin
         min_mag_ff <= min_mag_in;
         max_mag_ff <= max_mag_in;
      end
      if (en_sq) begin
         sq_min_ff <= sq_min_in;
         sq_max_ff <= sq_max_in;
      end
   end

   assign sq_min = sq_min_ff;
   assign sq_max = sq_max_ff;

endmodule

>>> sv/bmm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_merge: combine the axis lanes
// Sums the squared gaps and the squared spans of all lanes into two
// registered totals.
// ----------------------------------------------------------------------------
module bmm_merge (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic [bmm_pkg::AXES-1:0][bmm_pkg::SQ_W-1:0] sq_min,
   input  logic [bmm_pkg::AXES-1:0][bmm_pkg::SQ_W-1:0] sq_max,
   output logic [bmm_pkg::SUM_W-1:0]                 sum_min,
   output logic [bmm_pkg::SUM_W-1:0]                 sum_max
);

   localparam int UW = bmm_pkg::SUM_W;

   logic [UW-1:0] sum_min_in, sum_max_in;
   logic [UW-1:0] sum_min_ff, sum_max_ff;

   always_comb begin
      sum_min_in = '0;
      sum_max_in = '0;
      for (int k = 0; k < bmm_pkg::AXES; k++) begin
         sum_min_in = sum_min_in + UW'(sq_min[k]);
         sum_max_in = sum_max_in + UW'(sq_max[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_min_ff <= sum_min_in;
         sum_max_ff <= sum_max_in;
      end
   end

   assign sum_min = sum_min_ff;
   assign sum_max = sum_max_ff;

endmodule

>>> sv/bmm_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_sqrt_pipe: pipelined integer square root
// One root bit per stage, most significant first, by trial subtraction of
// the running remainder.
// ----------------------------------------------------------------------------
module bmm_sqrt_pipe (
   input  logic                              clock,
   input  logic [bmm_pkg::ROOT_W-1:0]        en,
   input  logic [bmm_pkg::SUM_W-1:0]         radicand,
   output logic [bmm_pkg::ROOT_W-1:0]        root
);

   localparam int RW = bmm_pkg::ROOT_W;
   localparam int UW = bmm_pkg::SUM_W;
   localparam int TW = bmm_pkg::TEST_W;

   logic [UW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int BIT = RW - 1 - s;
      logic [UW-1:0] rem_prev, rem_in;
      logic [RW-1:0] root_prev, root_in;
      logic [TW-1:0] test;

      if (s == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      always_comb begin
         test = (TW'(root_prev) << (BIT + 1)) + (TW'(1) << (2 * BIT));
         if (TW'(rem_prev) >= test) begin
            rem_in  = UW'(TW'(rem_prev) - test);
            root_in = root_prev | (RW'(1) << BIT);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

>>> sv/box_min_max_distance_3d_unit.sv
`timescale 1ns / 1ps
// A request passes the lane magnitude and square stages, the merge stage and the root stages.
// Throughput: one request per cycle; each stage advances when it is empty or its
// successor advances, so bubbles close up behind a waiting response.
// Pipeline depth is set by the square root, one root bit per stage.
// Reset clears only the stage valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// box_min_max_distance_3d_unit: min and max distance between two 3D boxes
// Three axis lanes, a merging adder stage and two square root pipelines.
// ----------------------------------------------------------------------------
module box_min_max_distance_3d_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bmm_pkg::bmm_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bmm_pkg::bmm_rsp_type  rsp_data
);

   localparam int NS = bmm_pkg::NUM_ST;
   localparam int FS = bmm_pkg::FRONT_ST;
   localparam int RW = bmm_pkg::ROOT_W;
   localparam int NA = bmm_pkg::AXES;

   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] en;

   bmm_pkg::coord_type [NA-1:0] a_low, a_high, b_low, b_high;
   logic [NA-1:0][bmm_pkg::SQ_W-1:0] sq_min, sq_max;
   logic [bmm_pkg::SUM_W-1:0] sum_min, sum_max;
   logic [RW-1:0] root_min, root_max;

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         if (en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NS-1];

   assign a_low  = {req_data.a_low_z,  req_data.a_low_y,  req_data.a_low_x};
   assign a_high = {req_data.a_high_z, req_data.a_high_y, req_data.a_high_x};
   assign b_low  = {req_data.b_low_z,  req_data.b_low_y,  req_data.b_low_x};
   assign b_high = {req_data.b_high_z, req_data.b_high_y, req_data.b_high_x};

   for (genvar k = 0; k < NA; k++) begin : g_lane
      bmm_axis_lane u_lane (
         .clock  (clock),
         .en_mag (en[0]),
         .en_sq  (en[1]),
         .a_low  (a_low[k]),
         .a_high (a_high[k]),
         .b_low  (b_low[k]),
         .b_high (b_high[k]),
         .sq_min (sq_min[k]),
         .sq_max (sq_max[k])
      );
   end

   bmm_merge u_merge (
      .clock   (clock),
      .en      (en[2]),
      .sq_min  (sq_min),
      .sq_max  (sq_max),
      .sum_min (sum_min),
      .sum_max (sum_max)
   );

   bmm_sqrt_pipe u_sqrt_min (
      .clock    (clock),
      .en       (en[NS-1:FS]),
      .radicand (sum_min),
      .root     (root_min)
   );

   bmm_sqrt_pipe u_sqrt_max (
      .clock    (clock),
      .en       (en[NS-1:FS]),
      .radicand (sum_max),
      .root     (root_max)
   );

   assign rsp_data.min_distance = bmm_pkg::OUT_W'(root_min);
   assign rsp_data.max_distance = bmm_pkg::OUT_W'(root_max);

endmodule
